// ----- rtl/tlqe_pkg.sv -----
// ----------------------------------------------------------------------------
// tlqe_pkg
// Shared types and constants of the thick line quad expander.
// ----------------------------------------------------------------------------
package tlqe_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned WidthBits = 31;
  localparam int unsigned MagBits   = 30;
  localparam int unsigned PointBits = CoordBits + 1;

  localparam logic [WidthBits-1:0] JoinThresh = WidthBits'(2) << FracBits;

  typedef enum logic [2:0] {
    REG_MAT_A        = 3'd0,
    REG_MAT_B        = 3'd1,
    REG_MAT_C        = 3'd2,
    REG_MAT_D        = 3'd3,
    REG_MAT_TX       = 3'd4,
    REG_MAT_TY       = 3'd5,
    REG_STROKE_WIDTH = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_JOIN  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_NONE  = 2'd3
  } quad_kind_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] a;
    logic signed [CoordBits-1:0] b;
    logic signed [CoordBits-1:0] c;
    logic signed [CoordBits-1:0] d;
    logic signed [CoordBits-1:0] tx;
    logic signed [CoordBits-1:0] ty;
  } mat_t;

  typedef struct packed {
    logic signed [PointBits-1:0] x;
    logic signed [PointBits-1:0] y;
  } point_t;

endpackage

// ----- rtl/tlqe_sqrt.sv -----
// ----------------------------------------------------------------------------
// tlqe_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module tlqe_sqrt import tlqe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [2*MagBits:0]     radicand_i,
  output logic                   done_o,
  output logic [WidthBits-1:0]   root_o
);

  localparam int unsigned SqW = 2 * MagBits + 2;

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [SqW-1:0] rem_q, rem_d;
  logic [SqW-1:0] res_q, res_d;
  logic [SqW-1:0] bit_q, bit_d;
  logic [SqW-1:0] trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = SqW'(radicand_i);
      res_d  = '0;
      bit_d  = SqW'(1) << (2 * MagBits);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[WidthBits-1:0];

endmodule

// ----- rtl/tlqe_div.sv -----
// ----------------------------------------------------------------------------
// tlqe_div
// Product then restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlqe_div import tlqe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WidthBits-1:0] hw_i,
  input  logic [MagBits-1:0]   mag_i,
  input  logic [WidthBits-1:0] len_i,
  output logic                 done_o,
  output logic [WidthBits-1:0] quot_o
);

  localparam int unsigned ProdW = WidthBits + MagBits;
  localparam int unsigned CntW  = $clog2(WidthBits);

  logic             mul_q, mul_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [WidthBits-1:0] rem_q, rem_d;
  logic [WidthBits-1:0] low_q, low_d;
  logic [WidthBits-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WidthBits:0] shifted;

  assign shifted = {rem_q, low_q[WidthBits-1]};

  always_comb begin
    mul_d  = 1'b0;
    run_d  = run_q;
    done_d = 1'b0;
    prod_d = prod_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      mul_d  = 1'b1;
      prod_d = ProdW'(hw_i) * ProdW'(mag_i);
    end else if (mul_q) begin
      run_d  = 1'b1;
      rem_d  = WidthBits'(prod_q[ProdW-1:WidthBits]);
      low_d  = prod_q[WidthBits-1:0];
      quot_d = '0;
      cnt_d  = CntW'(WidthBits - 1);
    end else if (run_q) begin
      low_d = low_q << 1;
      if (shifted >= {1'b0, len_i}) begin
        rem_d  = WidthBits'(shifted - {1'b0, len_i});
        quot_d = {quot_q[WidthBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted[WidthBits-1:0];
        quot_d = {quot_q[WidthBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= mul_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    low_q  <= low_d;
    quot_q <= quot_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/tlqe_xform.sv -----
// ----------------------------------------------------------------------------
// tlqe_xform
// Affine map of four points with one shared multiplier, one coordinate at a time.
// ----------------------------------------------------------------------------
module tlqe_xform import tlqe_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  mat_t                        mat_i,
  input  point_t                      pts_i [4],
  output logic                        done_o,
  output logic signed [CoordBits-1:0] res_o [8]
);

  localparam int unsigned ProdW = CoordBits + PointBits;
  localparam int unsigned AccW  = ProdW + 1;
  localparam int unsigned SumW  = AccW - FracBits;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [1:0]               phase_q, phase_d;
  logic [2:0]               crd_q, crd_d;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [CoordBits-1:0] res_q [8];

  logic                        is_y;
  point_t                      pt;
  logic signed [CoordBits-1:0] m1, m2, trans;
  logic signed [PointBits-1:0] v1, v2;
  logic signed [AccW-1:0]      shifted;
  logic signed [SumW-1:0]      sum;
  logic signed [CoordBits-1:0] sat;

  assign is_y  = crd_q[0];
  assign pt    = pts_i[crd_q[2:1]];
  assign m1    = is_y ? mat_i.b : mat_i.a;
  assign m2    = is_y ? mat_i.d : mat_i.c;
  assign trans = is_y ? mat_i.ty : mat_i.tx;
  assign v1    = pt.x;
  assign v2    = pt.y;

  assign shifted = acc_q >>> FracBits;
  assign sum     = SumW'(shifted) + SumW'(trans);

  always_comb begin
    if (!sum[SumW-1] && (|sum[SumW-2:CoordBits-1])) begin
      sat = {1'b0, {(CoordBits-1){1'b1}}};
    end else if (sum[SumW-1] && !(&sum[SumW-2:CoordBits-1])) begin
      sat = {1'b1, {(CoordBits-1){1'b0}}};
    end else begin
      sat = sum[CoordBits-1:0];
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    crd_d   = crd_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = '0;
      crd_d   = '0;
    end else if (busy_q) begin
      phase_d = phase_q + 1'b1;
      unique case (phase_q)
        2'd0: prod_d = m1 * v1;
        2'd1: begin
          acc_d  = AccW'(prod_q);
          prod_d = m2 * v2;
        end
        2'd2: acc_d = acc_q + AccW'(prod_q);
        default: begin
          crd_d = crd_q + 1'b1;
          if (&crd_q) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;
    crd_q   <= crd_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    if (busy_q && (phase_q == 2'd3)) begin
      res_q[crd_q] <= sat;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- rtl/thick_line_quad_expander.sv -----
// ----------------------------------------------------------------------------
// thick_line_quad_expander
// Expands one path segment into a body quad plus optional join quads.
// ----------------------------------------------------------------------------
// One segment is taken at a time; the input stalls until its last quad is
// loaded into the output register. After a segment is accepted the block
// takes, scales and squares the differences, runs the bit-serial square root,
// reuses the divider for each normal term (skipped for a zero-length
// segment), runs the affine unit that uses one multiplier over all eight
// coordinates, then emits one quad per cycle while the output is not
// stalled. A segment yields one to three quads, the last one flagged by
// last_of_run_o.
module thick_line_quad_expander import tlqe_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [2:0]                  cfg_index_i,
  input  logic [CoordBits-1:0]        cfg_data_i,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  input  logic [WidthBits-1:0]        start_half_width_i,
  input  logic [WidthBits-1:0]        end_half_width_i,
  input  logic                        first_segment_i,
  input  logic                        close_path_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [CoordBits-1:0] corner0_x_o,
  output logic signed [CoordBits-1:0] corner0_y_o,
  output logic signed [CoordBits-1:0] corner1_x_o,
  output logic signed [CoordBits-1:0] corner1_y_o,
  output logic signed [CoordBits-1:0] corner2_x_o,
  output logic signed [CoordBits-1:0] corner2_y_o,
  output logic signed [CoordBits-1:0] corner3_x_o,
  output logic signed [CoordBits-1:0] corner3_y_o,
  output logic [1:0]                  quad_kind_o,
  output logic                        last_of_run_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCALE = 7'b0000010,
    ST_SQSUM = 7'b0000100,
    ST_SQRT  = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_XFORM = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  mat_t                   mat_q;
  logic [WidthBits-1:0]   stroke_q;
  reg_idx_e               cfg_idx;

  logic signed [CoordBits-1:0] ax_q, ay_q, bx_q, by_q;
  logic [WidthBits-1:0]   aw_q, bw_q;
  logic                   first_q, close_q;
  logic [MagBits-1:0]     mx_q, my_q;
  logic                   dx_pos_q, dy_neg_q;
  logic [2*MagBits:0]     sqsum_q;
  logic [WidthBits-1:0]   len_q;
  logic signed [CoordBits-1:0] term_q [4];
  logic [1:0]             term_idx_q;
  logic                   launched_q, launched_d;
  logic                   join_q, cjoin_q;
  quad_kind_e             sel_q;

  logic signed [CoordBits-1:0] prev_q [4];
  logic signed [CoordBits-1:0] first_edge_q [4];
  logic                   prev_valid_q, first_valid_q;

  logic                   out_valid_q;
  logic signed [CoordBits-1:0] corner_q [8];
  quad_kind_e             kind_q;
  logic                   last_q;

  logic                   in_acc, load;
  logic signed [CoordBits:0] dx, dy;
  logic [CoordBits:0]     mdx, mdy, mor;
  logic [MagBits-1:0]     mdx_s, mdy_s;

  logic                   sqrt_start, sqrt_done;
  logic [WidthBits-1:0]   sqrt_root;
  logic                   div_start, div_done;
  logic [WidthBits-1:0]   div_quot;
  logic [WidthBits-1:0]   div_hw;
  logic [MagBits-1:0]     div_mag;
  logic                   div_neg;
  logic                   xf_start, xf_done;
  point_t                 pts [4];
  logic signed [CoordBits-1:0] body [8];

  logic                   thick, join_now, cjoin_now, last_now;
  logic signed [CoordBits-1:0] quad [8];

  assign cfg_ready = 1'b1;
  assign cfg_idx   = reg_idx_e'(cfg_index_i);
  assign in_stall  = (state_q != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign thick     = (stroke_q > JoinThresh);

  assign dx  = (CoordBits+1)'(bx_q) - (CoordBits+1)'(ax_q);
  assign dy  = (CoordBits+1)'(by_q) - (CoordBits+1)'(ay_q);
  assign mdx = dx[CoordBits] ? (CoordBits+1)'(-dx) : dx;
  assign mdy = dy[CoordBits] ? (CoordBits+1)'(-dy) : dy;
  assign mor = mdx | mdy;

  always_comb begin
    priority if (mor[CoordBits]) begin
      mdx_s = MagBits'(mdx >> 3);
      mdy_s = MagBits'(mdy >> 3);
    end else if (mor[CoordBits-1]) begin
      mdx_s = MagBits'(mdx >> 2);
      mdy_s = MagBits'(mdy >> 2);
    end else if (mor[CoordBits-2]) begin
      mdx_s = MagBits'(mdx >> 1);
      mdy_s = MagBits'(mdy >> 1);
    end else begin
      mdx_s = MagBits'(mdx);
      mdy_s = MagBits'(mdy);
    end
  end

  assign div_hw  = term_idx_q[1] ? bw_q : aw_q;
  assign div_mag = term_idx_q[0] ? mx_q : my_q;
  assign div_neg = term_idx_q[0] ? dx_pos_q : dy_neg_q;

  assign sqrt_start = (state_q == ST_SQRT) && !launched_q;
  assign div_start  = (state_q == ST_DIV) && !launched_q && (len_q != '0);
  assign xf_start   = (state_q == ST_XFORM) && !launched_q;

  always_comb begin
    pts[0].x = (PointBits)'(ax_q) + (PointBits)'(term_q[0]);
    pts[0].y = (PointBits)'(ay_q) + (PointBits)'(term_q[1]);
    pts[1].x = (PointBits)'(ax_q) - (PointBits)'(term_q[0]);
    pts[1].y = (PointBits)'(ay_q) - (PointBits)'(term_q[1]);
    pts[2].x = (PointBits)'(bx_q) - (PointBits)'(term_q[2]);
    pts[2].y = (PointBits)'(by_q) - (PointBits)'(term_q[3]);
    pts[3].x = (PointBits)'(bx_q) + (PointBits)'(term_q[2]);
    pts[3].y = (PointBits)'(by_q) + (PointBits)'(term_q[3]);
  end

  tlqe_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqsum_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  tlqe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hw_i    (div_hw),
    .mag_i   (div_mag),
    .len_i   (len_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  tlqe_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (xf_start),
    .mat_i   (mat_q),
    .pts_i   (pts),
    .done_o  (xf_done),
    .res_o   (body)
  );

  assign join_now  = thick && !first_q && prev_valid_q;
  assign cjoin_now = thick && close_q && (first_valid_q || !join_now);

  assign load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

  always_comb begin
    unique case (sel_q)
      KIND_JOIN: begin
        last_now = !cjoin_q;
        for (int i = 0; i < 4; i++) begin
          quad[i]     = body[i];
          quad[i + 4] = prev_q[i];
        end
      end
      KIND_CLOSE: begin
        last_now = 1'b1;
        for (int i = 0; i < 4; i++) begin
          quad[i]     = body[i + 4];
          quad[i + 4] = first_edge_q[i];
        end
      end
      default: begin
        last_now = !(join_q || cjoin_q);
        for (int i = 0; i < 8; i++) begin
          quad[i] = body[i];
        end
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SQSUM;
      ST_SQSUM: begin
        state_d    = ST_SQRT;
        launched_d = 1'b0;
      end
      ST_SQRT: begin
        launched_d = 1'b1;
        if (sqrt_done) begin
          state_d    = ST_DIV;
          launched_d = 1'b0;
        end
      end
      ST_DIV: begin
        launched_d = 1'b1;
        if (len_q == '0) begin
          state_d    = ST_XFORM;
          launched_d = 1'b0;
        end else if (div_done) begin
          launched_d = 1'b0;
          if (&term_idx_q) state_d = ST_XFORM;
        end
      end
      ST_XFORM: begin
        launched_d = 1'b1;
        if (xf_done) state_d = ST_EMIT;
      end
      ST_EMIT:  if (load && last_now) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      launched_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      prev_valid_q  <= 1'b0;
      first_valid_q <= 1'b0;
      mat_q.a       <= CoordBits'(1) << FracBits;
      mat_q.b       <= '0;
      mat_q.c       <= '0;
      mat_q.d       <= CoordBits'(1) << FracBits;
      mat_q.tx      <= '0;
      mat_q.ty      <= '0;
      stroke_q      <= WidthBits'(1) << FracBits;
      for (int i = 0; i < 4; i++) begin
        prev_q[i]       <= '0;
        first_edge_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (cfg_valid) begin
        unique case (cfg_idx)
          REG_MAT_A:        mat_q.a  <= cfg_data_i;
          REG_MAT_B:        mat_q.b  <= cfg_data_i;
          REG_MAT_C:        mat_q.c  <= cfg_data_i;
          REG_MAT_D:        mat_q.d  <= cfg_data_i;
          REG_MAT_TX:       mat_q.tx <= cfg_data_i;
          REG_MAT_TY:       mat_q.ty <= cfg_data_i;
          REG_STROKE_WIDTH: stroke_q <= cfg_data_i[WidthBits-1:0];
          default:          ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_XFORM) && xf_done && thick && !join_now) begin
        first_valid_q <= 1'b1;
        for (int i = 0; i < 4; i++) first_edge_q[i] <= body[i];
      end
      if (load && last_now && thick && !cjoin_q) begin
        prev_valid_q <= 1'b1;
        for (int i = 0; i < 4; i++) prev_q[i] <= body[i + 4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q    <= start_x_i;
      ay_q    <= start_y_i;
      bx_q    <= end_x_i;
      by_q    <= end_y_i;
      aw_q    <= start_half_width_i;
      bw_q    <= end_half_width_i;
      first_q <= first_segment_i;
      close_q <= close_path_i;
    end
    if (state_q == ST_SCALE) begin
      mx_q       <= mdx_s;
      my_q       <= mdy_s;
      dx_pos_q   <= !dx[CoordBits] && (dx != '0);
      dy_neg_q   <= dy[CoordBits];
      term_idx_q <= '0;
      for (int i = 0; i < 4; i++) term_q[i] <= '0;
    end
    if (state_q == ST_SQSUM) begin
      sqsum_q <= (2*MagBits+1)'(mx_q) * (2*MagBits+1)'(mx_q)
               + (2*MagBits+1)'(my_q) * (2*MagBits+1)'(my_q);
    end
    if ((state_q == ST_SQRT) && sqrt_done) begin
      len_q <= sqrt_root;
    end
    if ((state_q == ST_DIV) && div_done) begin
      term_q[term_idx_q] <= div_neg ? -CoordBits'(div_quot) : CoordBits'(div_quot);
      term_idx_q         <= term_idx_q + 1'b1;
    end
    if ((state_q == ST_XFORM) && xf_done) begin
      join_q  <= join_now;
      cjoin_q <= cjoin_now;
      sel_q   <= KIND_BODY;
    end
    if (load) begin
      corner_q <= quad;
      kind_q   <= sel_q;
      last_q   <= last_now;
      sel_q    <= ((sel_q == KIND_BODY) && join_q) ? KIND_JOIN : KIND_CLOSE;
    end
  end

  assign out_valid     = out_valid_q;
  assign corner0_x_o   = corner_q[0];
  assign corner0_y_o   = corner_q[1];
  assign corner1_x_o   = corner_q[2];
  assign corner1_y_o   = corner_q[3];
  assign corner2_x_o   = corner_q[4];
  assign corner2_y_o   = corner_q[5];
  assign corner3_x_o   = corner_q[6];
  assign corner3_y_o   = corner_q[7];
  assign quad_kind_o   = kind_q;
  assign last_of_run_o = last_q;

endmodule
